// File: rtl/core/sbrc_pkg.sv
// Shared types, widths and helpers for the soft bar row color unit.
// No dependencies; imported by every module under rtl/core.
package sbrc_pkg;

  localparam int MAX_ROWS  = 1024;
  localparam int COLOR_W   = 32;
  localparam int H_W       = 11;
  localparam int ROW_W     = 10;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 3;

  // middle-row divisor is height-3, at most MAX_ROWS-3
  localparam int N_W      = 10;
  // shade spread between +12 and -12 is at most 24, so the quotient fits 5 bits
  localparam int MAG_W    = 5;
  localparam int DIV_BITS = 5;
  localparam int PROD_W   = MAG_W + ROW_W;

  localparam logic signed [6:0] SHADE_HI  = 7'sd28;
  localparam logic signed [6:0] SHADE_MID = 7'sd12;

  typedef enum logic [1:0] {
    KIND_FLAT   = 2'd0,
    KIND_TOP    = 2'd1,
    KIND_MID    = 2'd2,
    KIND_BOTTOM = 2'd3
  } row_kind_t;

  typedef struct packed {
    logic      drawn;
    row_kind_t kind;
    logic [7:0] alpha;
  } sbrc_side_t;

  function automatic logic [7:0] sat_shift(logic [7:0] x, logic signed [6:0] d);
    logic signed [9:0] s;
    s = $signed({2'b00, x}) + $signed({{3{d[6]}}, d});
    if (s < 10'sd0) begin
      return 8'h00;
    end else if (s > 10'sd255) begin
      return 8'hFF;
    end else begin
      return s[7:0];
    end
  endfunction

endpackage

// File: rtl/core/soft_bar_row_color_unit.sv
// Top level of the soft bar row color unit: input stage, row decode, three lanes, merge.
// Depends on sbrc_pkg, sbrc_lane and sbrc_merge.
//
//  channel | dir | signals                  | beat contents
//  s_      | in  | tvalid tready tdata      | base_color, bar_height, row_index
//  m_      | out | tvalid tready tdata tuser| row_color; row_kind, drawn
//
// One beat accepted per clock, sustained while m_tready is high. m_tvalid rises once
// the input beat has passed the input register, shade setup, 5 divider stages and
// the output register.
// Each stage holds only while its successor is full, so bubbles close up.
// rst clears all stage valid flags and holds s_tready low; data registers are not reset.
module soft_bar_row_color_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] base_color, [42:32] bar_height, [52:43] row_index, [55:53] zero
  input  logic [sbrc_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] row_color
  output logic [sbrc_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // [1:0] row_kind, [2] drawn
  output logic [sbrc_pkg::OUT_TUSER_W-1:0]  m_tuser
);
  import sbrc_pkg::*;

  localparam int LAST = DIV_BITS + 1;
  localparam int NSTG = DIV_BITS + 3;

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] ld;

  logic [COLOR_W-1:0] base_q;
  logic [H_W-1:0]     h_q;
  logic [ROW_W-1:0]   row_q;
  logic [H_W-1:0]     h_in;

  sbrc_side_t side_c;
  sbrc_side_t side [1:LAST];
  logic       use_div_c;
  logic [N_W-1:0]   n_c;
  logic [ROW_W-1:0] j_c;

  logic [7:0] lane_out [0:2];
  row_kind_t  kind_out;
  logic       drawn_out;
  logic [COLOR_W-1:0] color_out;

  always_comb begin
    rdy[NSTG-1] = !v[NSTG-1] || m_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
    ld[0] = rdy[0] && s_tvalid;
    for (int k = 1; k < NSTG; k++) begin
      ld[k] = rdy[k] && v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= s_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign s_tready = rdy[0] && !rst;
  assign m_tvalid = v[NSTG-1];

  assign h_in = (s_tdata[42:32] > H_W'(MAX_ROWS)) ? H_W'(MAX_ROWS) : s_tdata[42:32];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      base_q <= s_tdata[31:0];
      h_q    <= h_in;
      row_q  <= s_tdata[52:43];
    end
  end

  always_comb begin
    side_c.alpha = base_q[31:24];
    side_c.drawn = ({1'b0, row_q} < h_q);
    use_div_c    = 1'b0;
    if (h_q < H_W'(3)) begin
      side_c.kind = KIND_FLAT;
    end else if (row_q == '0) begin
      side_c.kind = KIND_TOP;
    end else if ({1'b0, row_q} == h_q - H_W'(1)) begin
      side_c.kind = KIND_BOTTOM;
    end else begin
      side_c.kind = KIND_MID;
      use_div_c   = (h_q != H_W'(3));
    end
    n_c = N_W'(h_q - H_W'(3));
    j_c = row_q - ROW_W'(1);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      side[1] <= side_c;
    end
    for (int k = 2; k <= LAST; k++) begin
      if (ld[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    sbrc_lane u_lane (
      .clk      (clk),
      .en       (ld[LAST:1]),
      .chan     (base_q[8*g +: 8]),
      .j        (j_c),
      .n        (n_c),
      .kind     (side_c.kind),
      .use_div  (use_div_c),
      .chan_out (lane_out[g])
    );
  end

  sbrc_merge u_merge (
    .clk       (clk),
    .load      (ld[NSTG-1]),
    .ch_r      (lane_out[2]),
    .ch_g      (lane_out[1]),
    .ch_b      (lane_out[0]),
    .side      (side[LAST]),
    .row_color (color_out),
    .row_kind  (kind_out),
    .drawn     (drawn_out)
  );

  assign m_tdata = color_out;
  assign m_tuser = {drawn_out, kind_out};

endmodule

// File: rtl/core/sbrc_lane.sv
// One color channel lane: shade setup, then a restoring divider, one quotient bit per stage.
// Depends on sbrc_pkg; stage enables come from the top-level pipeline control.
module sbrc_lane (
  input  logic                          clk,
  input  logic [sbrc_pkg::DIV_BITS:0]   en,
  input  logic [7:0]                    chan,
  input  logic [sbrc_pkg::ROW_W-1:0]    j,
  input  logic [sbrc_pkg::N_W-1:0]      n,
  input  sbrc_pkg::row_kind_t           kind,
  input  logic                          use_div,
  output logic [7:0]                    chan_out
);
  import sbrc_pkg::*;

  logic [PROD_W-1:0]   rem     [0:DIV_BITS];
  logic [DIV_BITS-1:0] quo     [0:DIV_BITS];
  logic [7:0]          top_val [0:DIV_BITS];
  logic [7:0]          fixed   [0:DIV_BITS];
  logic [N_W-1:0]      dvs     [0:DIV_BITS];
  logic                sel_div [0:DIV_BITS];

  logic [7:0]        a_c;
  logic [7:0]        b_c;
  logic [MAG_W-1:0]  mag_c;
  logic [PROD_W-1:0] prod_c;
  logic [7:0]        fixed_c;

  always_comb begin
    a_c    = sat_shift(chan, SHADE_MID);
    b_c    = sat_shift(chan, -SHADE_MID);
    mag_c  = MAG_W'(a_c - b_c);
    prod_c = PROD_W'(mag_c) * PROD_W'(j);
    case (kind)
      KIND_TOP:    fixed_c = sat_shift(chan, SHADE_HI);
      KIND_BOTTOM: fixed_c = sat_shift(chan, -SHADE_HI);
      KIND_MID:    fixed_c = a_c;
      default:     fixed_c = chan;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]     <= prod_c;
      quo[0]     <= '0;
      top_val[0] <= a_c;
      fixed[0]   <= fixed_c;
      dvs[0]     <= n;
      sel_div[0] <= use_div;
    end
    for (int i = 1; i <= DIV_BITS; i++) begin
      if (en[i]) begin
        if (rem[i-1] >= (PROD_W'(dvs[i-1]) << (DIV_BITS - i))) begin
          rem[i] <= rem[i-1] - (PROD_W'(dvs[i-1]) << (DIV_BITS - i));
          quo[i] <= quo[i-1] | (DIV_BITS'(1) << (DIV_BITS - i));
        end else begin
          rem[i] <= rem[i-1];
          quo[i] <= quo[i-1];
        end
        top_val[i] <= top_val[i-1];
        fixed[i]   <= fixed[i-1];
        dvs[i]     <= dvs[i-1];
        sel_div[i] <= sel_div[i-1];
      end
    end
  end

  // spread is never negative, so truncation toward zero is a plain subtract
  assign chan_out = sel_div[DIV_BITS] ? top_val[DIV_BITS] - 8'(quo[DIV_BITS])
                                      : fixed[DIV_BITS];

endmodule

// File: rtl/core/sbrc_merge.sv
// Output register: drawn flag plus, for drawn rows, three lanes, alpha and kind.
// Depends on sbrc_pkg; loaded by the top-level pipeline control.
module sbrc_merge (
  input  logic                          clk,
  input  logic                          load,
  input  logic [7:0]                    ch_r,
  input  logic [7:0]                    ch_g,
  input  logic [7:0]                    ch_b,
  input  sbrc_pkg::sbrc_side_t          side,
  output logic [sbrc_pkg::COLOR_W-1:0]  row_color,
  output sbrc_pkg::row_kind_t           row_kind,
  output logic                          drawn
);
  import sbrc_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      if (side.drawn) begin
        row_color <= {side.alpha, ch_r, ch_g, ch_b};
        row_kind  <= side.kind;
      end else begin
        row_color <= '0;
        row_kind  <= KIND_FLAT;
      end
      drawn <= side.drawn;
    end
  end

endmodule
